FILE: design/cau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Types and constants shared by the complex arithmetic unit modules.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int QUO_W       = DATA_WIDTH + 1;
  localparam int DIV_STEPS   = QUO_W;
  localparam int SQRT_STEPS  = DATA_WIDTH;
  localparam int LANE_LAT    = DIV_STEPS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAG = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;

  typedef enum logic [5:0] {
    CLS_ADD  = 6'b000001,
    CLS_SUB  = 6'b000010,
    CLS_MUL  = 6'b000100,
    CLS_DIV  = 6'b001000,
    CLS_MAG  = 6'b010000,
    CLS_NONE = 6'b100000
  } cls_t;

  typedef struct packed {
    logic [2:0]                   op;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         equal;
    logic                         div_zero;
    logic                         saturated;
  } cau_out_t;

  typedef struct packed {
    cls_t                         cls;
    logic                         equal;
    logic                         div_zero;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } cau_item_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } cau_qstat_t;

endpackage
`default_nettype wire

FILE: design/cau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Accepts request beats, classifies the operation and feeds the queue.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cau_pkg::cau_in_t   req,
  input  cau_pkg::cau_qstat_t qstat,
  output logic               push,
  output cau_pkg::cau_item_t item
);
  import cau_pkg::*;

  logic      fv;
  cau_item_t fitem;
  cau_item_t item_next;

  assign req_ready = !fv || !qstat.full;
  assign push      = fv && !qstat.full;
  assign item      = fitem;

  always_comb begin
    item_next          = '0;
    item_next.equal    = (req.a_re == req.b_re) && (req.a_im == req.b_im);
    item_next.div_zero = 1'b0;
    item_next.a_re     = req.a_re;
    item_next.a_im     = req.a_im;
    item_next.b_re     = req.b_re;
    item_next.b_im     = req.b_im;
    case (req.op)
      OP_ADD: begin
        item_next.cls = CLS_ADD;
      end
      OP_SUB: begin
        item_next.cls = CLS_SUB;
      end
      OP_MUL: begin
        item_next.cls = CLS_MUL;
      end
      OP_DIV: begin
        if (req.b_re == '0 && req.b_im == '0) begin
          item_next.cls      = CLS_NONE;
          item_next.div_zero = 1'b1;
        end else begin
          item_next.cls = CLS_DIV;
        end
      end
      OP_MAG: begin
        // squares of a come out of the same multipliers
        item_next.cls  = CLS_MAG;
        item_next.b_re = req.a_re;
        item_next.b_im = req.a_im;
      end
      OP_CMP: begin
        item_next.cls = CLS_NONE;
      end
      default: begin
        item_next.cls = CLS_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (req_ready) begin
      fv <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      fitem <= item_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/cau_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module cau_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cau_pkg::cau_item_t  push_item,
  input  logic                pop,
  output cau_pkg::cau_item_t  head,
  output cau_pkg::cau_qstat_t qstat
);
  import cau_pkg::*;

  cau_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign head           = mem[rptr];
  assign qstat.nonempty = (count != '0);
  assign qstat.full     = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: design/cau_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cau_div_pipe (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cau_pkg::PROD_W-1:0] num,
  input  logic [cau_pkg::PROD_W-1:0] den,
  output logic [cau_pkg::QUO_W-1:0]  quo,
  output logic                       big
);
  import cau_pkg::*;

  localparam int SHIFT = QUO_W - FRAC_BITS;

  logic [PROD_W-1:0] rem_q    [DIV_STEPS+1];
  logic [PROD_W-1:0] den_q    [DIV_STEPS+1];
  logic [QUO_W-1:0]  rest_q   [DIV_STEPS+1];
  logic [QUO_W-1:0]  quo_q    [DIV_STEPS+1];
  logic              big_q    [DIV_STEPS+1];
  logic [PROD_W:0]   rs       [1:DIV_STEPS];
  logic [PROD_W:0]   df       [1:DIV_STEPS];
  logic [PROD_W-1:0] rem_next [1:DIV_STEPS];
  logic [QUO_W-1:0]  quo_next [1:DIV_STEPS];

  always_comb begin
    for (int k = 1; k <= DIV_STEPS; k++) begin
      rs[k]       = {rem_q[k-1], rest_q[k-1][QUO_W-1]};
      df[k]       = rs[k] - {1'b0, den_q[k-1]};
      rem_next[k] = df[k][PROD_W] ? rs[k][PROD_W-1:0] : df[k][PROD_W-1:0];
      quo_next[k] = {quo_q[k-1][QUO_W-2:0], !df[k][PROD_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= num >> SHIFT;
      den_q[0]  <= den;
      rest_q[0] <= QUO_W'({num, {FRAC_BITS{1'b0}}});
      quo_q[0]  <= '0;
      big_q[0]  <= (num >> SHIFT) >= den;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        rem_q[k]  <= rem_next[k];
        den_q[k]  <= den_q[k-1];
        rest_q[k] <= rest_q[k-1] << 1;
        quo_q[k]  <= quo_next[k];
        big_q[k]  <= big_q[k-1];
      end
    end
  end

  assign quo = quo_q[DIV_STEPS];
  assign big = big_q[DIV_STEPS];

endmodule
`default_nettype wire

FILE: design/cau_sqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_sqrt_pipe
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cau_sqrt_pipe (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cau_pkg::PROD_W-1:0] val,
  output logic [cau_pkg::QUO_W-1:0]  root
);
  import cau_pkg::*;

  logic [PROD_W-1:0] v_q    [SQRT_STEPS+1];
  logic [PROD_W-1:0] r_q    [SQRT_STEPS+1];
  logic [PROD_W-1:0] t      [1:SQRT_STEPS];
  logic [PROD_W-1:0] v_next [1:SQRT_STEPS];
  logic [PROD_W-1:0] r_next [1:SQRT_STEPS];

  always_comb begin
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      t[k] = r_q[k-1] + (PROD_W'(1) << (PROD_W - 2 * k));
      if (v_q[k-1] >= t[k]) begin
        v_next[k] = v_q[k-1] - t[k];
        r_next[k] = (r_q[k-1] >> 1) + (PROD_W'(1) << (PROD_W - 2 * k));
      end else begin
        v_next[k] = v_q[k-1];
        r_next[k] = r_q[k-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_q[0] <= val;
      r_q[0] <= '0;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        v_q[k] <= v_next[k];
        r_q[k] <= r_next[k];
      end
      // align with the divider lanes
      root <= r_q[SQRT_STEPS][QUO_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: design/cau_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, divide and root lanes, saturation.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                clk,
  input  logic                rst,
  input  cau_pkg::cau_item_t  head,
  input  cau_pkg::cau_qstat_t qstat,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cau_pkg::cau_out_t   rsp
);
  import cau_pkg::*;

  localparam int SUM_W  = DATA_WIDTH + 1;
  localparam int WIDE_W = PROD_W + 1;
  localparam logic [PROD_W-1:0] MAG_POS =
    {{(PROD_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [PROD_W-1:0] MAG_NEG =
    {{(PROD_W-DATA_WIDTH){1'b0}}, 1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    cls_t cls;
    logic equal;
    logic div_zero;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic              neg_re;
    logic              neg_im;
    logic [PROD_W-1:0] mag_re;
    logic [PROD_W-1:0] mag_im;
  } side_t;

  function automatic logic [DATA_WIDTH:0] clip_word(
    input logic neg, input logic big, input logic [PROD_W-1:0] mag);
    logic [DATA_WIDTH:0] r;
    if (!neg && (big || mag > MAG_POS)) begin
      r = {1'b1, 1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (neg && (big || mag > MAG_NEG)) begin
      r = {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else if (neg) begin
      r = {1'b0, -mag[DATA_WIDTH-1:0]};
    end else begin
      r = {1'b0, mag[DATA_WIDTH-1:0]};
    end
    return r;
  endfunction

  logic en;

  // stage 1: products and add/subtract sums
  logic                     v1;
  tag_t                     tag1;
  logic signed [PROD_W-1:0] ar_x, ai_x, br_x, bi_x;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
  logic signed [SUM_W-1:0]  as_re, as_im;

  // stage 2: sums
  logic                     v2;
  tag_t                     tag2;
  logic signed [WIDE_W-1:0] sr, si, sr_next, si_next;
  logic [PROD_W-1:0]        den2;

  // stage 3: sign and magnitude, with the multiply fraction shift
  logic                     v3;
  tag_t                     tag3;
  logic [WIDE_W-1:0]        abs_re, abs_im;
  logic                     neg_re3, neg_im3;
  logic [PROD_W-1:0]        mag3_re, mag3_im, den3;

  // lanes
  logic [QUO_W-1:0]         quo_re, quo_im, root;
  logic                     big_re, big_im;
  logic [LANE_LAT-1:0]      side_v;
  side_t                    side_q [LANE_LAT];
  side_t                    fin;

  // output register
  logic                     out_v;
  cau_out_t                 out_q, out_next;
  logic [DATA_WIDTH:0]      cr, ci;

  assign en        = !out_v || rsp_ready;
  assign pop       = en && qstat.nonempty;
  assign rsp_valid = out_v;
  assign rsp       = out_q;

  assign ar_x = PROD_W'(head.a_re);
  assign ai_x = PROD_W'(head.a_im);
  assign br_x = PROD_W'(head.b_re);
  assign bi_x = PROD_W'(head.b_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      side_v <= '0;
      out_v  <= 1'b0;
    end else if (en) begin
      v1     <= qstat.nonempty;
      v2     <= v1;
      v3     <= v2;
      side_v <= {side_v[LANE_LAT-2:0], v3};
      out_v  <= side_v[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1 <= '{cls: head.cls, equal: head.equal, div_zero: head.div_zero};
      p_rr <= ar_x * br_x;
      p_ii <= ai_x * bi_x;
      p_ri <= ar_x * bi_x;
      p_ir <= ai_x * br_x;
      p_br <= br_x * br_x;
      p_bi <= bi_x * bi_x;
      if (head.cls == CLS_SUB) begin
        as_re <= SUM_W'(head.a_re) - SUM_W'(head.b_re);
        as_im <= SUM_W'(head.a_im) - SUM_W'(head.b_im);
      end else begin
        as_re <= SUM_W'(head.a_re) + SUM_W'(head.b_re);
        as_im <= SUM_W'(head.a_im) + SUM_W'(head.b_im);
      end
    end
  end

  always_comb begin
    case (tag1.cls)
      CLS_MUL: begin
        sr_next = WIDE_W'(p_rr) - WIDE_W'(p_ii);
        si_next = WIDE_W'(p_ri) + WIDE_W'(p_ir);
      end
      CLS_DIV: begin
        sr_next = WIDE_W'(p_rr) + WIDE_W'(p_ii);
        si_next = WIDE_W'(p_ir) - WIDE_W'(p_ri);
      end
      CLS_MAG: begin
        sr_next = WIDE_W'(p_rr) + WIDE_W'(p_ii);
        si_next = '0;
      end
      default: begin
        sr_next = WIDE_W'(as_re);
        si_next = WIDE_W'(as_im);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag2 <= tag1;
      sr   <= sr_next;
      si   <= si_next;
      den2 <= $unsigned(p_br) + $unsigned(p_bi);
    end
  end

  always_comb begin
    abs_re = sr[WIDE_W-1] ? -sr : sr;
    abs_im = si[WIDE_W-1] ? -si : si;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3    <= tag2;
      neg_re3 <= sr[WIDE_W-1];
      neg_im3 <= si[WIDE_W-1];
      den3    <= den2;
      if (tag2.cls == CLS_MUL) begin
        mag3_re <= abs_re[PROD_W-1:0] >> FRAC_BITS;
        mag3_im <= abs_im[PROD_W-1:0] >> FRAC_BITS;
      end else begin
        mag3_re <= abs_re[PROD_W-1:0];
        mag3_im <= abs_im[PROD_W-1:0];
      end
    end
  end

  cau_div_pipe u_div_re (
    .clk (clk),
    .en  (en),
    .num (mag3_re),
    .den (den3),
    .quo (quo_re),
    .big (big_re)
  );

  cau_div_pipe u_div_im (
    .clk (clk),
    .en  (en),
    .num (mag3_im),
    .den (den3),
    .quo (quo_im),
    .big (big_im)
  );

  cau_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (en),
    .val  (mag3_re),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= '{tag: tag3, neg_re: neg_re3, neg_im: neg_im3,
                     mag_re: mag3_re, mag_im: mag3_im};
      for (int k = 1; k < LANE_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign fin = side_q[LANE_LAT-1];

  always_comb begin
    cr = '0;
    ci = '0;
    case (fin.tag.cls)
      CLS_ADD, CLS_SUB, CLS_MUL: begin
        cr = clip_word(fin.neg_re, 1'b0, fin.mag_re);
        ci = clip_word(fin.neg_im, 1'b0, fin.mag_im);
      end
      CLS_DIV: begin
        cr = clip_word(fin.neg_re, big_re, PROD_W'(quo_re));
        ci = clip_word(fin.neg_im, big_im, PROD_W'(quo_im));
      end
      CLS_MAG: begin
        cr = clip_word(1'b0, 1'b0, PROD_W'(root));
      end
      default: begin
        cr = '0;
        ci = '0;
      end
    endcase
    out_next.res_re    = cr[DATA_WIDTH-1:0];
    out_next.res_im    = ci[DATA_WIDTH-1:0];
    out_next.equal     = fin.tag.equal;
    out_next.div_zero  = fin.tag.div_zero;
    out_next.saturated = cr[DATA_WIDTH] | ci[DATA_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= out_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/complex_arith_unit.sv
`default_nettype none
// throughput: one beat per cycle while rsp_ready does not stall the output; set by the
// pipelined 33-stage divider lanes and 32-stage square root lane, which take a new
// operand set every cycle that the output register can advance
// reset: synchronous, active high; clears all valid flags and the queue pointers
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex Q16.16 add, subtract, multiply, divide, magnitude and compare.
// ----------------------------------------------------------------------------
module complex_arith_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cau_pkg::cau_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cau_pkg::cau_out_t rsp
);
  import cau_pkg::*;

  logic       push;
  logic       pop;
  cau_item_t  f_item;
  cau_item_t  head;
  cau_qstat_t qstat;

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .qstat     (qstat),
    .push      (push),
    .item      (f_item)
  );

  cau_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.nonempty)
    else $error("pop from empty queue");

  a_div_zero_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_zero |-> rsp.res_re == '0 && rsp.res_im == '0 && !rsp.saturated)
    else $error("divide by zero beat carries data");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.saturated |-> rsp.res_re == WORD_MAX || rsp.res_re == WORD_MIN ||
      rsp.res_im == WORD_MAX || rsp.res_im == WORD_MIN)
    else $error("saturated beat not at a range limit");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_complex_arith_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// Drives operand beats through the complex arithmetic unit with bursty input
// and a stalling output, predicts every response in Q16.16 and checks it in order.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;
  import cau_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  cau_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  cau_out_t rsp;

  int n_errors = 0;
  bit hold_off = 1'b0;

  complex_arith_unit i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] clip32(input logic signed [127:0] v, ref bit sat);
    if (v > 128'sh7fffffff) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // truncate toward zero: shift magnitude
  function automatic logic signed [127:0] trunc_shift(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = v < 0 ? -v : v;
    m = m >>> FRAC_BITS;
    return v < 0 ? -m : m;
  endfunction

  // quotient toward zero at FRAC_BITS fraction bits
  function automatic logic signed [127:0] fix_quot(input logic signed [127:0] num,
                                                   input logic signed [127:0] den);
    logic signed [127:0] m;
    m = num < 0 ? -num : num;
    m = (m <<< FRAC_BITS) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cau_out_t complex_result(input cau_in_t x);
    cau_out_t o;
    bit sat;
    logic signed [127:0] ar, ai, br, bi, den;
    ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im;
    o = '0;
    sat = 1'b0;
    o.equal = (x.a_re == x.b_re) && (x.a_im == x.b_im);
    case (x.op)
      OP_ADD: begin
        o.res_re = clip32(ar + br, sat);
        o.res_im = clip32(ai + bi, sat);
      end
      OP_SUB: begin
        o.res_re = clip32(ar - br, sat);
        o.res_im = clip32(ai - bi, sat);
      end
      OP_MUL: begin
        o.res_re = clip32(trunc_shift(ar * br - ai * bi), sat);
        o.res_im = clip32(trunc_shift(ar * bi + ai * br), sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.div_zero = 1'b1;
        end else begin
          o.res_re = clip32(fix_quot(ar * br + ai * bi, den), sat);
          o.res_im = clip32(fix_quot(ai * br - ar * bi, den), sat);
        end
      end
      OP_MAG: begin
        den = ar * ar + ai * ai;
        o.res_re = clip32({64'd0, int_sqrt(den[63:0])}, sat);
      end
      default: ;
    endcase
    o.saturated = sat;
    return o;
  endfunction

  class result_scoreboard;
    cau_out_t pending[$];

    function void note_request(cau_in_t x);
      pending.push_back(complex_result(x));
    endfunction

    task check_response(cau_out_t got);
      cau_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat", got.res_re, 32'h0);
        return;
      end
      want = pending.pop_front();
      if (got.res_re !== want.res_re) report_mismatch("res_re", got.res_re, want.res_re);
      if (got.res_im !== want.res_im) report_mismatch("res_im", got.res_im, want.res_im);
      if (got.equal !== want.equal) report_mismatch("equal", got.equal, want.equal);
      if (got.div_zero !== want.div_zero)
        report_mismatch("div_zero", got.div_zero, want.div_zero);
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", got.saturated, want.saturated);
    endtask
  endclass

  result_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) sb.note_request(req);
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) begin
      rsp_ready <= 1'b0;
    end else begin
      case ($urandom_range(3))
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(3) != 0);
        2: rsp_ready <= 1'($urandom_range(1));
        default: rsp_ready <= ($urandom_range(4) == 0);
      endcase
    end
  end

  function automatic logic [31:0] pick_part();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(1) ? 32'h00010000 : 32'hffff0000;
      4: return $signed($urandom_range(65535)) - 32768;
      5: return {{12{$urandom_range(1) ? 1'b1 : 1'b0}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input cau_in_t x);
    req_valid <= 1'b1;
    req <= x;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    cau_in_t x;
    x.op = op; x.a_re = ar; x.a_im = ai; x.b_re = br; x.b_im = bi;
    send_beat(x);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    cau_in_t x;
    int burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_op(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_op(OP_SUB, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_op(OP_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00020000);
    send_op(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_op(OP_MUL, 32'hffffffff, 32'h00000001, 32'h00000001, 32'h00000001);
    send_op(OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hfffb0000);
    send_op(OP_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
    send_op(OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 32'h0);
    send_op(OP_DIV, 32'h80000000, 32'h0, 32'h80000000, 32'h0);
    send_op(OP_DIV, 32'h00050000, 32'hfffd0000, 32'h00010000, 32'h00020000);
    send_op(OP_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_op(OP_MAG, 32'h00030000, 32'h00040000, 32'h1, 32'h2);
    send_op(OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(OP_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0);
    send_op(OP_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1);
    send_op(3'd6, 32'h1, 32'h2, 32'h1, 32'h2);
    send_op(3'd7, 32'hffffffff, 32'h0, 32'h1, 32'h0);

    // long receiver hold-off while input keeps flowing
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (60) begin
        x = {3'($urandom_range(7)), pick_part(), pick_part(), pick_part(), pick_part()};
        send_beat(x);
      end
    join

    for (int i = 0; i < 2000; ) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst; k++) begin
        x.op = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                         : 3'($urandom_range(5));
        x.a_re = pick_part(); x.a_im = pick_part();
        x.b_re = pick_part(); x.b_im = pick_part();
        if ($urandom_range(7) == 0) begin
          x.b_re = x.a_re; x.b_im = x.a_im;
        end
        if (x.op == OP_DIV && $urandom_range(9) == 0) begin
          x.b_re = '0; x.b_im = '0;
        end
        send_beat(x);
        i++;
      end
      idle_gap($urandom_range(3) == 0 ? 0 : $urandom_range(12));
    end
    req_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LANE_LAT + 20) @(posedge clk);
    if (n_errors == 0) $display("complex_arith_unit test passed");
    else $display("complex_arith_unit test failed");
    $finish;
  end

  initial begin
    #400000;
    $display("complex_arith_unit test failed");
    $finish;
  end

endmodule
